// ===== hw/rtl/cpts_pkg.sv =====
// cpts_pkg: shared constants, request/result types, controller states and
// the command/status structs between controller and datapath.
// no dependencies
`timescale 1ns / 1ps

package cpts_pkg;

    localparam int TASK_SLOTS   = 16;
    localparam int COUNTER_BITS = 8;
    localparam int SLOT_W       = (TASK_SLOTS > 2) ? $clog2(TASK_SLOTS) : 1;
    localparam int PRIO_W       = 8;
    localparam int SUM_W        = ((COUNTER_BITS > PRIO_W) ? COUNTER_BITS : PRIO_W) + 1;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] slot;
        logic [7:0] task_priority;
        logic [7:0] counter_start;
    } request_t;

    typedef struct packed {
        logic [3:0] running_slot;
        logic       switched;
        logic [7:0] running_counter;
        logic       refilled;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CHECK,
        S_REFILL,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic refill_init;
        logic refill_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_sched;
        logic scan_last;
        logic refill_last;
        logic best_none;
        logic any_valid;
        logic refill_done;
    } status_t;

endpackage

// ===== hw/rtl/counter_priority_task_scheduler_top.sv =====
// counter_priority_task_scheduler_top: counter/priority task-slot scheduler
// top level, joins cpts_ctrl and cpts_dp. depends on cpts_pkg
//
//   channel   handshake        payload               accepted when
//   request   start / busy     request (request_t)   start high, busy low
//   result    done             result (result_t)     done high, one cycle
//
// load, clear and unused modes go from accept through S_EXEC to S_RESULT and done.
// a tick that schedules adds a scan of slots TASK_SLOTS-1 down to 1 and one check;
// with a refill, a refill pass over slots 1 to TASK_SLOTS-1, a second scan and a
// second check follow; the scan takes one slot per cycle.
// busy is high from accept until the done cycle ends; done cannot be stalled.
// reset clears the valid bits and the running slot at once, no clearing pass.
`timescale 1ns / 1ps

module counter_priority_task_scheduler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cpts_pkg::request_t request,
    output logic               done,
    output cpts_pkg::result_t  result
);

    cpts_pkg::cmd_t    cmd;
    cpts_pkg::status_t status;

    cpts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cpts_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

// ===== hw/rtl/cpts_ctrl.sv =====
// cpts_ctrl: scheduler controller state machine, sequences execute, scan, check,
// refill and result steps. depends on cpts_pkg
`timescale 1ns / 1ps

module cpts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cpts_pkg::status_t status,
    output cpts_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    cpts_pkg::state_t state_reg;
    cpts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            cpts_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = cpts_pkg::S_EXEC;
                end
            end
            cpts_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_sched)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = cpts_pkg::S_SCAN;
                end
                else
                begin
                    state_next = cpts_pkg::S_RESULT;
                end
            end
            cpts_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = cpts_pkg::S_CHECK;
                end
            end
            cpts_pkg::S_CHECK:
            begin
                if (status.best_none && status.any_valid && !status.refill_done)
                begin
                    cmd.refill_init = 1'b1;
                    state_next      = cpts_pkg::S_REFILL;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = cpts_pkg::S_RESULT;
                end
            end
            cpts_pkg::S_REFILL:
            begin
                cmd.refill_step = 1'b1;
                if (status.refill_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = cpts_pkg::S_SCAN;
                end
            end
            cpts_pkg::S_RESULT:
            begin
                done       = 1'b1;
                state_next = cpts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cpts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cpts_dp.sv =====
// cpts_dp: scheduler datapath, slot tables, running slot, scan index and
// best-candidate registers. depends on cpts_pkg
`timescale 1ns / 1ps

module cpts_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  cpts_pkg::request_t request,
    input  cpts_pkg::cmd_t     cmd,
    output cpts_pkg::status_t  status,
    output cpts_pkg::result_t  result
);

    localparam int SW = cpts_pkg::SLOT_W;
    localparam int CW = cpts_pkg::COUNTER_BITS;
    localparam int PW = cpts_pkg::PRIO_W;
    localparam int NW = cpts_pkg::SUM_W;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [SW-1:0] IDX_LAST = SW'(cpts_pkg::TASK_SLOTS - 1);
    localparam logic [SW-1:0] IDX_FIRST = SW'(1);

    logic                valid_reg [cpts_pkg::TASK_SLOTS];
    logic [CW-1:0]       cnt_reg   [cpts_pkg::TASK_SLOTS];
    logic [PW-1:0]       prio_reg  [cpts_pkg::TASK_SLOTS];

    cpts_pkg::request_t  req_reg;
    logic [SW-1:0]       cur_reg;
    logic [SW-1:0]       old_slot_reg;
    logic [SW-1:0]       idx_reg;
    logic [SW-1:0]       best_reg;
    logic [CW-1:0]       best_cnt_reg;
    logic                any_valid_reg;
    logic                refilled_reg;

    logic [SW-1:0]       rd_addr;
    logic                rd_valid;
    logic [CW-1:0]       rd_cnt;
    logic [PW-1:0]       rd_prio;

    logic                req_slot_ok;
    logic [SW-1:0]       req_idx;
    logic [CW-1:0]       load_cnt;
    logic [CW-1:0]       dec_cnt;
    logic [NW-1:0]       refill_sum;
    logic [CW-1:0]       refill_cnt;
    logic                is_tick;

    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    logic                wr_valid;
    logic [CW-1:0]       wr_cnt;
    logic [PW-1:0]       wr_prio;

    // read port
    assign rd_addr  = (cmd.scan_step || cmd.refill_step) ? idx_reg : cur_reg;
    assign rd_valid = valid_reg[rd_addr];
    assign rd_cnt   = cnt_reg[rd_addr];
    assign rd_prio  = prio_reg[rd_addr];

    assign req_slot_ok = (req_reg.slot != 4'd0)
                      && (32'(req_reg.slot) < 32'(cpts_pkg::TASK_SLOTS));
    assign req_idx     = SW'(req_reg.slot);
    assign load_cnt    = (64'(req_reg.counter_start) > 64'(CNT_MAX))
                       ? CNT_MAX : CW'(req_reg.counter_start);
    assign dec_cnt     = (rd_cnt == '0) ? '0 : rd_cnt - CW'(1);
    assign refill_sum  = NW'(rd_cnt >> 1) + NW'(rd_prio);
    assign refill_cnt  = (refill_sum > NW'(CNT_MAX)) ? CNT_MAX : CW'(refill_sum);
    assign is_tick     = (req_reg.mode == cpts_pkg::MODE_TICK);

    // write port
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = cur_reg;
        wr_valid = rd_valid;
        wr_cnt   = rd_cnt;
        wr_prio  = rd_prio;
        if (cmd.exec)
        begin
            unique case (req_reg.mode)
                cpts_pkg::MODE_LOAD:
                begin
                    wr_en    = req_slot_ok;
                    wr_addr  = req_idx;
                    wr_valid = 1'b1;
                    wr_cnt   = load_cnt;
                    wr_prio  = req_reg.task_priority;
                end
                cpts_pkg::MODE_CLEAR:
                begin
                    wr_en    = req_slot_ok;
                    wr_addr  = req_idx;
                    wr_valid = 1'b0;
                    wr_cnt   = '0;
                    wr_prio  = '0;
                end
                cpts_pkg::MODE_TICK:
                begin
                    wr_en   = (cur_reg != '0) && rd_valid;
                    wr_addr = cur_reg;
                    wr_cnt  = dec_cnt;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.refill_step)
        begin
            wr_en   = rd_valid;
            wr_addr = idx_reg;
            wr_cnt  = refill_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpts_pkg::TASK_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= wr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_reg[wr_addr]  <= wr_cnt;
            prio_reg[wr_addr] <= wr_prio;
        end
    end

    // running slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (cmd.commit)
        begin
            cur_reg <= best_reg;
        end
    end

    // request capture, scan and refill bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= request;
            old_slot_reg <= cur_reg;
            refilled_reg <= 1'b0;
        end
        if (cmd.refill_init)
        begin
            refilled_reg <= 1'b1;
        end

        if (cmd.scan_init)
        begin
            idx_reg       <= IDX_LAST;
            best_reg      <= '0;
            best_cnt_reg  <= '0;
            any_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg - SW'(1);
            if (rd_valid)
            begin
                any_valid_reg <= 1'b1;
            end
            if (rd_valid && (rd_cnt > best_cnt_reg))
            begin
                best_reg     <= idx_reg;
                best_cnt_reg <= rd_cnt;
            end
        end
        else if (cmd.refill_init)
        begin
            idx_reg <= IDX_FIRST;
        end
        else if (cmd.refill_step)
        begin
            idx_reg <= idx_reg + SW'(1);
        end
    end

    assign status.need_sched  = is_tick
                             && ((cur_reg == '0) || !rd_valid || (dec_cnt == '0));
    assign status.scan_last   = (idx_reg == IDX_FIRST);
    assign status.refill_last = (idx_reg == IDX_LAST);
    assign status.best_none   = (best_reg == '0);
    assign status.any_valid   = any_valid_reg;
    assign status.refill_done = refilled_reg;

    assign result.running_slot    = 4'(cur_reg);
    assign result.switched        = (cur_reg != old_slot_reg);
    assign result.running_counter = ((cur_reg != '0) && rd_valid) ? 8'(rd_cnt) : 8'd0;
    assign result.refilled        = refilled_reg;

endmodule
